// ===== src/scpg_pkg.sv =====
// Package: constants, types and the clamp function of the six-channel servo pulse generator.
package scpg_pkg;

	localparam int MAX_CHANNELS = 6;
	localparam int CHANNELS     = 6;

	localparam int DEMAND_W   = 16;
	localparam int PULSE_W    = 12;
	localparam int COUNT_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [PULSE_W-1:0] CLAMP_LO_RESET     = 12'd904;
	localparam logic [PULSE_W-1:0] CLAMP_HI_RESET     = 12'd2200;
	localparam logic [COUNT_W-1:0] FRAME_PERIOD_RESET = 16'd20000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLAMP_LO     = 2'd0,
		REG_CLAMP_HI     = 2'd1,
		REG_FRAME_PERIOD = 2'd2
	} cfg_reg_t;

	typedef logic signed [DEMAND_W-1:0] demand_t;
	typedef logic [PULSE_W-1:0]         pulse_t;
	typedef logic [COUNT_W-1:0]         count_t;

	typedef struct packed {
		logic   adv;
		logic   start;
		count_t frame_count;
		pulse_t clamp_lo;
		pulse_t clamp_hi;
	} chan_ctl_t;

	// when min > max, demands below the lower bound get it, all others get the upper bound
	function automatic pulse_t clamp_width(demand_t d, pulse_t lo, pulse_t hi);
		logic signed [DEMAND_W:0] dx;
		logic signed [DEMAND_W:0] lox;
		logic signed [DEMAND_W:0] hix;
		dx  = {d[DEMAND_W-1], d};
		lox = $signed({{(DEMAND_W-PULSE_W+1){1'b0}}, lo});
		hix = $signed({{(DEMAND_W-PULSE_W+1){1'b0}}, hi});
		if (dx < lox)
			return lo;
		else if (dx > hix)
			return hi;
		else
			return d[PULSE_W-1:0];
	endfunction

endpackage

// ===== src/scpg_if.sv =====
// Interfaces: demand input channel, level result channel and register write channel.
interface scpg_in_if
	import scpg_pkg::*;
();
	logic    valid;
	logic    ready;
	demand_t demand_one;
	demand_t demand_two;
	demand_t demand_three;
	demand_t demand_four;
	demand_t demand_five;
	demand_t demand_six;

	modport source (output valid, demand_one, demand_two, demand_three, demand_four,
		demand_five, demand_six, input ready);
	modport sink (input valid, demand_one, demand_two, demand_three, demand_four,
		demand_five, demand_six, output ready);
endinterface

interface scpg_res_if;
	logic valid;
	logic ready;
	logic level_one;
	logic level_two;
	logic level_three;
	logic level_four;
	logic level_five;
	logic level_six;
	logic frame_start;

	modport source (output valid, level_one, level_two, level_three, level_four,
		level_five, level_six, frame_start, input ready);
	modport sink (input valid, level_one, level_two, level_three, level_four,
		level_five, level_six, frame_start, output ready);
endinterface

interface scpg_cfg_if
	import scpg_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/scpg_chan.sv =====
// One servo channel: latched width register, clamp at frame start, level compare.
module scpg_chan
	import scpg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  chan_ctl_t ctl,
	input  demand_t   demand,
	output logic      level
);

	pulse_t width_q;
	pulse_t width;

	// new frame uses the freshly clamped demand on the same tick
	assign width = ctl.start ? clamp_width(demand, ctl.clamp_lo, ctl.clamp_hi) : width_q;
	assign level = ctl.frame_count < {{(COUNT_W-PULSE_W){1'b0}}, width};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= '0;
		end else if (ctl.adv && ctl.start) begin
			width_q <= width;
		end
	end

endmodule

// ===== src/six_channel_servo_pulse_generator_top.sv =====
// Top level of the six-channel servo pulse generator.
//
//  channel | dir | handshake       | payload
//  --------+-----+-----------------+-------------------------------------------
//  in_ch   | in  | valid / ready   | demand_one .. demand_six, signed 16 bit
//  res_ch  | out | valid / ready   | level_one .. level_six, frame_start
//  cfg     | in  | valid / ready   | index (2 bit), data (16 bit)
//
// One tick per transaction: a transaction is registered in the input stage, then the
// frame counter, clamp and compares run on it into the result register when it advances.
// One transaction per cycle sustained while the result is not stalled.
// Reset clears the frame counter and latched widths and loads register defaults.
// A stalled result holds both stages; cfg is always ready.
module six_channel_servo_pulse_generator_top
	import scpg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	scpg_in_if.sink    in_ch,
	scpg_res_if.source res_ch,
	scpg_cfg_if.sink   cfg
);

	pulse_t clamp_lo_q;
	pulse_t clamp_hi_q;
	count_t frame_period_q;

	logic    valid_s1;
	demand_t demand_s1 [MAX_CHANNELS];

	count_t frame_count_q;
	logic   adv;
	logic   start;
	logic [COUNT_W:0] count_inc;
	count_t count_next;

	logic                    res_valid_q;
	logic [MAX_CHANNELS-1:0] level_q;
	logic                    frame_start_q;
	logic [MAX_CHANNELS-1:0] level;
	chan_ctl_t               ctl;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_lo_q     <= CLAMP_LO_RESET;
			clamp_hi_q     <= CLAMP_HI_RESET;
			frame_period_q <= FRAME_PERIOD_RESET;
		end else if (cfg.valid) begin
			case (cfg_reg_t'(cfg.index))
				REG_CLAMP_LO:     clamp_lo_q     <= cfg.data[PULSE_W-1:0];
				REG_CLAMP_HI:     clamp_hi_q     <= cfg.data[PULSE_W-1:0];
				REG_FRAME_PERIOD: frame_period_q <= cfg.data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input stage
	assign adv         = valid_s1 && (!res_valid_q || res_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			demand_s1[0] <= in_ch.demand_one;
			demand_s1[1] <= in_ch.demand_two;
			demand_s1[2] <= in_ch.demand_three;
			demand_s1[3] <= in_ch.demand_four;
			demand_s1[4] <= in_ch.demand_five;
			demand_s1[5] <= in_ch.demand_six;
		end
	end

	// frame counter; a period of zero behaves as one
	assign start      = frame_count_q == '0;
	assign count_inc  = {1'b0, frame_count_q} + {{COUNT_W{1'b0}}, 1'b1};
	assign count_next = (count_inc >= {1'b0, frame_period_q}) ? '0 : count_inc[COUNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (adv) begin
			frame_count_q <= count_next;
		end
	end

	assign ctl = '{adv: adv, start: start, frame_count: frame_count_q,
		clamp_lo: clamp_lo_q, clamp_hi: clamp_hi_q};

	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_chan
		if (c < CHANNELS) begin : g_used
			scpg_chan u_chan (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.demand (demand_s1[c]),
				.level  (level[c])
			);
		end else begin : g_unused
			assign level[c] = 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q       <= level;
			frame_start_q <= start;
		end
	end

	assign res_ch.valid       = res_valid_q;
	assign res_ch.level_one   = level_q[0];
	assign res_ch.level_two   = level_q[1];
	assign res_ch.level_three = level_q[2];
	assign res_ch.level_four  = level_q[3];
	assign res_ch.level_five  = level_q[4];
	assign res_ch.level_six   = level_q[5];
	assign res_ch.frame_start = frame_start_q;

`ifndef NO_ASSERTIONS
	a_adv_fills_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> res_valid_q)
		else $error("result register not loaded after advance");

	a_start_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && start |=> frame_start_q)
		else $error("frame start not flagged");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (frame_count_q == $past(frame_count_q) + 16'd1) || (frame_count_q == '0))
		else $error("frame counter skipped");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(frame_count_q))
		else $error("frame counter moved without a transaction");
`endif

endmodule
